FILE: rtl/tanc_pkg.sv
// ----------------------------------------------------------------------------
// tanc_pkg
// Shared item types and constants for the tile average / nearest color unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tanc_pkg;

    localparam int CHAN_W        = 8;
    localparam int INDEX_W       = 8;
    localparam int ENTRY_COUNT_W = 9;
    localparam int SEARCH_CAP    = 256;
    localparam int DIST_W        = 18;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] entry_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic [CHAN_W-1:0]  mean_red;
        logic [CHAN_W-1:0]  mean_green;
        logic [CHAN_W-1:0]  mean_blue;
        logic               table_empty;
        logic               tile_overflow;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/tanc_front.sv
// ----------------------------------------------------------------------------
// tanc_front
// Accepts items, accumulates tile pixels and queues table loads and
// finished tile jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tanc_front #(
    parameter int MAX_TILE_PIXELS = 1024,
    parameter int CW = 11,
    parameter int SW = 18,
    parameter int QW = 2 + 11 + 3 * 18 + 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tanc_pkg::in_item_t s_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output logic [QW-1:0]          q_data
);

    logic [SW-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SW-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic          is_pixel;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_pixel = (s_data.kind == tanc_pkg::KIND_PIXEL);
    assign q_push   = accept && (!is_pixel || s_data.last_pixel);

    always_comb begin
        sum_r_next = sum_r_reg;
        sum_g_next = sum_g_reg;
        sum_b_next = sum_b_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        if (cnt_reg < CW'(MAX_TILE_PIXELS)) begin
            sum_r_next = sum_r_reg + SW'(s_data.red);
            sum_g_next = sum_g_reg + SW'(s_data.green);
            sum_b_next = sum_b_reg + SW'(s_data.blue);
            cnt_next   = cnt_reg + CW'(1);
        end else begin
            ovf_next = 1'b1;
        end
    end

    always_comb begin
        if (is_pixel) begin
            q_data = {1'b1, ovf_next, cnt_next, sum_b_next, sum_g_next, sum_r_next,
                      {tanc_pkg::INDEX_W{1'b0}}};
        end else begin
            q_data = {1'b0, 1'b0, {CW{1'b0}}, SW'(s_data.blue), SW'(s_data.green),
                      SW'(s_data.red), s_data.entry_index};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept && is_pixel) begin
            if (s_data.last_pixel) begin
                sum_r_reg <= '0;
                sum_g_reg <= '0;
                sum_b_reg <= '0;
                cnt_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_r_reg <= sum_r_next;
                sum_g_reg <= sum_g_next;
                sum_b_reg <= sum_b_next;
                cnt_reg   <= cnt_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tanc_queue.sv
// ----------------------------------------------------------------------------
// tanc_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tanc_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      head_data,
    output logic              full,
    output logic              empty
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign empty     = (fill_reg == 2'd0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tanc_back.sv
// ----------------------------------------------------------------------------
// tanc_back
// Executes queued jobs: table writes, per-channel division of tile sums and
// a pipelined walk of the color table for the nearest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tanc_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int CW = 11,
    parameter int SW = 18,
    parameter int QW = 2 + 11 + 3 * 18 + 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [tanc_pkg::ENTRY_COUNT_W-1:0] entry_count,
    input  wire logic [QW-1:0]         q_data,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tanc_pkg::out_item_t        m_data
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CAP  = (TABLE_DEPTH < tanc_pkg::SEARCH_CAP) ? TABLE_DEPTH
                                                              : tanc_pkg::SEARCH_CAP;
    localparam int DVW  = CW + 7;
    localparam int CMPW = SW + DVW;
    localparam int EW   = tanc_pkg::ENTRY_COUNT_W;
    localparam int IW   = tanc_pkg::INDEX_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic          u_tile, u_ovf;
    logic [CW-1:0] u_cnt;
    logic [SW-1:0] u_sb, u_sg, u_sr;
    logic [IW-1:0] u_idx;

    assign {u_tile, u_ovf, u_cnt, u_sb, u_sg, u_sr, u_idx} = q_data;

    logic [1:0]    state_reg;
    logic [SW-1:0] rem_r_reg, rem_g_reg, rem_b_reg;
    logic [DVW-1:0] div_reg;
    logic [7:0]    q_r_reg, q_g_reg, q_b_reg;
    logic [2:0]    step_reg;
    logic          ovf_reg;
    logic [EW-1:0] limit_reg, limit_next;
    logic [EW-1:0] issue_reg;
    logic          v1_reg, v2_reg;
    logic [IW-1:0] idx1_reg, idx2_reg;
    logic [15:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [IW-1:0] best_idx_reg;
    logic [tanc_pkg::DIST_W-1:0] best_dist_reg;
    logic          m_valid_reg;
    tanc_pkg::out_item_t out_reg;

    logic [23:0]   table_mem [TABLE_DEPTH];
    logic [23:0]   rdata_reg;
    logic [AW+7:0] ld_ext;
    logic [AW-1:0] rd_addr;
    logic          ld_we;
    logic          rd_en;
    logic          search_done;
    logic          out_load;

    logic          ge_r, ge_g, ge_b;
    logic [15:0]   sq_r_next, sq_g_next, sq_b_next;
    logic [tanc_pkg::DIST_W-1:0] dist_sum;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d * d);
    endfunction

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign ld_ext = (AW + 8)'(u_idx);
    assign ld_we  = q_pop && !u_tile && (ld_ext < (AW + 8)'(TABLE_DEPTH));
    assign rd_addr = AW'(issue_reg);
    assign rd_en  = (state_reg == ST_SEARCH) && (issue_reg < limit_reg);
    assign search_done = (issue_reg == limit_reg) && !v1_reg && !v2_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign limit_next = (entry_count > EW'(CAP)) ? EW'(CAP) : entry_count;

    assign ge_r = CMPW'(rem_r_reg) >= CMPW'(div_reg);
    assign ge_g = CMPW'(rem_g_reg) >= CMPW'(div_reg);
    assign ge_b = CMPW'(rem_b_reg) >= CMPW'(div_reg);

    assign sq_r_next = sq_diff(rdata_reg[23:16], q_r_reg);
    assign sq_g_next = sq_diff(rdata_reg[15:8], q_g_reg);
    assign sq_b_next = sq_diff(rdata_reg[7:0], q_b_reg);
    assign dist_sum = tanc_pkg::DIST_W'(sq_r_reg) + tanc_pkg::DIST_W'(sq_g_reg)
                    + tanc_pkg::DIST_W'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            table_mem[ld_ext[AW-1:0]] <= {u_sr[7:0], u_sg[7:0], u_sb[7:0]};
        end
        rdata_reg <= table_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (q_pop && u_tile) begin
            rem_r_reg <= u_sr;
            rem_g_reg <= u_sg;
            rem_b_reg <= u_sb;
            div_reg   <= {u_cnt, 7'd0};
            ovf_reg   <= u_ovf;
            limit_reg <= limit_next;
        end else if (state_reg == ST_DIV) begin
            if (ge_r) rem_r_reg <= rem_r_reg - SW'(div_reg);
            if (ge_g) rem_g_reg <= rem_g_reg - SW'(div_reg);
            if (ge_b) rem_b_reg <= rem_b_reg - SW'(div_reg);
            div_reg <= div_reg >> 1;
            q_r_reg <= {q_r_reg[6:0], ge_r};
            q_g_reg <= {q_g_reg[6:0], ge_g};
            q_b_reg <= {q_b_reg[6:0], ge_b};
        end
        idx1_reg <= issue_reg[IW-1:0];
        if (v1_reg) begin
            sq_r_reg <= sq_r_next;
            sq_g_reg <= sq_g_next;
            sq_b_reg <= sq_b_next;
            idx2_reg <= idx1_reg;
        end
        if (q_pop && u_tile) begin
            best_idx_reg <= '0;
        end else if (v2_reg && (idx2_reg == '0 || dist_sum < best_dist_reg)) begin
            best_idx_reg  <= idx2_reg;
            best_dist_reg <= dist_sum;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            issue_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            if (rd_en) begin
                issue_reg <= issue_reg + EW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop && u_tile) begin
                        step_reg  <= '0;
                        issue_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7) begin
                        state_reg <= (limit_reg == '0) ? ST_DONE : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (search_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.best_index    <= best_idx_reg;
            out_reg.mean_red      <= q_r_reg;
            out_reg.mean_green    <= q_g_reg;
            out_reg.mean_blue     <= q_b_reg;
            out_reg.table_empty   <= (limit_reg == '0);
            out_reg.tile_overflow <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tile_average_nearest_color_unit.sv
// Items are taken one per cycle while the two-entry job queue has room.
// A tile result follows its last pixel through restoring division of the sums,
// one table read per entry for L = min(entry_count, TABLE_DEPTH, 256) entries
// and a drain of the search pipeline; the search is skipped when the table is empty.
// The back end works on one queued job at a time; a load is written when popped.
// aresetn (synchronous, active low) clears sums, queue, control and entry_count.
// ----------------------------------------------------------------------------
// tile_average_nearest_color_unit
// Tile color averaging with nearest reference color search.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_average_nearest_color_unit #(
    parameter int TABLE_DEPTH     = 256,
    parameter int MAX_TILE_PIXELS = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tanc_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tanc_pkg::out_item_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [tanc_pkg::ENTRY_COUNT_W-1:0] cfg_wr_data
);

    localparam int CW = $clog2(MAX_TILE_PIXELS + 1);
    localparam int SW = $clog2(MAX_TILE_PIXELS * 255 + 1);
    localparam int QW = 2 + CW + 3 * SW + tanc_pkg::INDEX_W;

    logic [tanc_pkg::ENTRY_COUNT_W-1:0] entry_count_reg;
    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    tanc_front #(
        .MAX_TILE_PIXELS(MAX_TILE_PIXELS),
        .CW(CW),
        .SW(SW),
        .QW(QW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    tanc_queue #(
        .W(QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    tanc_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CW(CW),
        .SW(SW),
        .QW(QW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_count (entry_count_reg),
        .q_data      (q_out),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire
